/* hdl/ddo_pkg.sv */
`default_nettype none

package ddo_pkg;

    // Years are shifted up by one full 400-year cycle so that every
    // intermediate day count stays non-negative.
    localparam logic [11:0] YEAR_SHIFT = 12'd400;

    // Days in a 400-year cycle and in a normal 100-year span.
    localparam int ERA_DAYS  = 146097;
    localparam int CENT_DAYS = 36524;

    // Reciprocals for exact division by a constant over the operand ranges
    // used here: floor(x / c) == (x * RECIP) >> SHIFT.
    localparam logic [12:0] RECIP_100  = 13'd5243;    // shift 19, x < 2^12
    localparam logic [18:0] RECIP_1460 = 19'd367720;  // shift 29, x < 2^18
    localparam logic [18:0] RECIP_365  = 19'd367720;  // shift 27, x < 2^18

    localparam logic signed [12:0] YEAR_MIN = 13'sd1903;
    localparam logic signed [12:0] YEAR_MAX = 13'sd2037;

    // Control and payload between the day-number front end and the
    // year split.
    typedef struct packed {
        logic        valid;
        logic [19:0] z;
    } dn_t;

    // Control and payload between the year split and the date back end.
    typedef struct packed {
        logic        valid;
        logic [2:0]  era;
        logic [17:0] doe;
        logic [8:0]  yoe;
    } sp_t;

    // First day of each month counted from March 1 (index 0 is March).
    function automatic logic [8:0] mp_start(input logic [3:0] mp);
        logic [8:0] start;
        case (mp)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd61;
            4'd3:    start = 9'd92;
            4'd4:    start = 9'd122;
            4'd5:    start = 9'd153;
            4'd6:    start = 9'd184;
            4'd7:    start = 9'd214;
            4'd8:    start = 9'd245;
            4'd9:    start = 9'd275;
            4'd10:   start = 9'd306;
            4'd11:   start = 9'd337;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

`default_nettype wire

/* hdl/ddo_dayno.sv */
`default_nettype none

module ddo_dayno (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [4:0]         day_in,
    input  wire logic [3:0]         month_in,
    input  wire logic [10:0]        year_in,
    input  wire logic signed [16:0] day_offset,
    output ddo_pkg::dn_t            dn
);

    logic        mon_zero;
    logic        mon_hi;
    logic        early;
    logic [3:0]  mnorm;
    logic [3:0]  mp;
    logic [24:0] cent_prod;

    logic [11:0] y2_next;
    logic [4:0]  cent_next;
    logic [17:0] dsum_next;
    logic [19:0] z_next;

    logic        v1_reg;
    logic [11:0] y2_reg;
    logic [4:0]  cent_reg;
    logic [17:0] dsum_reg;
    logic        v2_reg;
    logic [19:0] z_reg;

    // Stage 1: fold the month into 1..12, move January and February to the
    // end of the previous year, and take the century count of that year.
    always_comb begin
        mon_zero = (month_in == 4'd0);
        mon_hi   = (month_in > 4'd12);
        if (mon_zero) begin
            mnorm = 4'd12;
        end else if (mon_hi) begin
            mnorm = month_in - 4'd12;
        end else begin
            mnorm = month_in;
        end
        early = (mnorm <= 4'd2);
        mp    = early ? (mnorm + 4'd9) : (mnorm - 4'd3);

        y2_next = {1'b0, year_in} + ddo_pkg::YEAR_SHIFT + 12'(mon_hi)
                  - 12'(mon_zero) - 12'(early);
        cent_prod = 25'(y2_next) * 25'(ddo_pkg::RECIP_100);
        cent_next = cent_prod[23:19];
        dsum_next = {9'd0, ddo_pkg::mp_start(mp)} + {13'd0, day_in} - 18'd1
                    + {day_offset[16], day_offset};
    end

    // Stage 2: day count since March 1 of the shifted year zero.
    always_comb begin
        z_next = 20'(y2_reg) * 20'd365 + 20'(y2_reg[11:2]) - 20'(cent_reg)
                 + 20'(cent_reg[4:2]) + {{2{dsum_reg[17]}}, dsum_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y2_reg   <= y2_next;
            cent_reg <= cent_next;
            dsum_reg <= dsum_next;
            z_reg    <= z_next;
        end
    end

    assign dn = '{valid: v2_reg, z: z_reg};

endmodule

`default_nettype wire

/* hdl/ddo_yoe.sv */
`default_nettype none

module ddo_yoe (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         en,
    input  wire ddo_pkg::dn_t dn,
    output ddo_pkg::sp_t      sp
);

    logic [2:0]  era3_next;
    logic [17:0] doe3_next;
    logic [36:0] prod4;
    logic [6:0]  q4_next;
    logic [2:0]  c4_next;
    logic        e4_next;
    logic [17:0] x5;
    logic [36:0] prod5;
    logic [8:0]  yoe5_next;

    logic        v3_reg;
    logic [2:0]  era3_reg;
    logic [17:0] doe3_reg;
    logic        v4_reg;
    logic [2:0]  era4_reg;
    logic [17:0] doe4_reg;
    logic [6:0]  q4_reg;
    logic [2:0]  c4_reg;
    logic        e4_reg;
    logic        v5_reg;
    logic [2:0]  era5_reg;
    logic [17:0] doe5_reg;
    logic [8:0]  yoe5_reg;

    // Stage 3: split the day count into 400-year cycles and the day within.
    always_comb begin
        era3_next = '0;
        for (int k = 1; k <= 6; k++) begin
            if (dn.z >= 20'(k * ddo_pkg::ERA_DAYS)) begin
                era3_next = era3_next + 3'd1;
            end
        end
        doe3_next = 18'(dn.z - 20'(era3_next) * 20'(ddo_pkg::ERA_DAYS));
    end

    // Stage 4: leap-day corrections within the cycle.
    always_comb begin
        prod4   = 37'(doe3_reg) * 37'(ddo_pkg::RECIP_1460);
        q4_next = prod4[35:29];
        c4_next = '0;
        for (int k = 1; k <= 4; k++) begin
            if (doe3_reg >= 18'(k * ddo_pkg::CENT_DAYS)) begin
                c4_next = c4_next + 3'd1;
            end
        end
        e4_next = (doe3_reg == 18'(ddo_pkg::ERA_DAYS - 1));
    end

    // Stage 5: with the leap days removed, the year is a plain division by 365.
    always_comb begin
        x5        = doe4_reg - 18'(q4_reg) + 18'(c4_reg) - 18'(e4_reg);
        prod5     = 37'(x5) * 37'(ddo_pkg::RECIP_365);
        yoe5_next = prod5[35:27];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= dn.valid;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            era3_reg <= era3_next;
            doe3_reg <= doe3_next;
            era4_reg <= era3_reg;
            doe4_reg <= doe3_reg;
            q4_reg   <= q4_next;
            c4_reg   <= c4_next;
            e4_reg   <= e4_next;
            era5_reg <= era4_reg;
            doe5_reg <= doe4_reg;
            yoe5_reg <= yoe5_next;
        end
    end

    assign sp = '{valid: v5_reg, era: era5_reg, doe: doe5_reg, yoe: yoe5_reg};

endmodule

`default_nettype wire

/* hdl/ddo_civil.sv */
`default_nettype none

module ddo_civil (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         en,
    input  wire ddo_pkg::sp_t sp,
    output logic              out_valid,
    output logic [4:0]        day_out,
    output logic [3:0]        month_out,
    output logic [11:0]       year_out,
    output logic              out_of_range
);

    logic [1:0]  yc;
    logic [8:0]  doy6_next;
    logic [3:0]  mp;
    logic [8:0]  start;
    logic        early;
    logic [12:0] yr13;

    logic [4:0]  day_next;
    logic [3:0]  month_next;
    logic [11:0] year_next;
    logic        oor_next;

    logic        v6_reg;
    logic [8:0]  doy6_reg;
    logic [8:0]  yoe6_reg;
    logic [2:0]  era6_reg;
    logic        v7_reg;
    logic [4:0]  day_reg;
    logic [3:0]  month_reg;
    logic [11:0] year_reg;
    logic        oor_reg;

    // Stage 6: day within the March-based year.
    always_comb begin
        yc = '0;
        for (int k = 1; k <= 3; k++) begin
            if (sp.yoe >= 9'(k * 100)) begin
                yc = yc + 2'd1;
            end
        end
        doy6_next = 9'(sp.doe - 18'(sp.yoe) * 18'd365 - 18'(sp.yoe[8:2]) + 18'(yc));
    end

    // Stage 7: month by search over the month starts, then day and year.
    always_comb begin
        mp = '0;
        for (int k = 1; k <= 11; k++) begin
            if (doy6_reg >= ddo_pkg::mp_start(4'(k))) begin
                mp = mp + 4'd1;
            end
        end
        start      = ddo_pkg::mp_start(mp);
        early      = (mp >= 4'd10);
        day_next   = 5'(doy6_reg - start + 9'd1);
        month_next = early ? (mp - 4'd9) : (mp + 4'd3);
        yr13       = 13'(yoe6_reg) + 13'(era6_reg) * 13'd400 + 13'(early)
                     - 13'(ddo_pkg::YEAR_SHIFT);
        year_next  = yr13[11:0];
        oor_next   = ($signed(yr13) < ddo_pkg::YEAR_MIN)
                     || ($signed(yr13) > ddo_pkg::YEAR_MAX);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= sp.valid;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            doy6_reg  <= doy6_next;
            yoe6_reg  <= sp.yoe;
            era6_reg  <= sp.era;
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            oor_reg   <= oor_next;
        end
    end

    assign out_valid    = v7_reg;
    assign day_out      = day_reg;
    assign month_out    = month_reg;
    assign year_out     = year_reg;
    assign out_of_range = oor_reg;

endmodule

`default_nettype wire

/* hdl/date_day_offset.sv */
// Channel  | Handshake          | Payload
// ---------+--------------------+------------------------------------------------
// request  | s_valid / s_ready  | s_day_in, s_month_in, s_year_in, s_day_offset
// result   | m_valid / m_ready  | m_day_out, m_month_out, m_year_out,
//          |                    | m_out_of_range
//
// An accepted request moves through seven register stages to its result; one request
// is taken every cycle while results are taken. The seven register stages
// share one enable, so the depth of the pipeline sets the latency.
// Reset (aresetn low at a clock edge) clears all valid bits; no clearing pass.
// When a result waits in the output register, the whole pipeline holds and
// s_ready drops until the result is taken.
`default_nettype none

module date_day_offset (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [4:0]         s_day_in,
    input  wire logic [3:0]         s_month_in,
    input  wire logic [10:0]        s_year_in,
    input  wire logic signed [16:0] s_day_offset,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [4:0]              m_day_out,
    output logic [3:0]              m_month_out,
    output logic [11:0]             m_year_out,
    output logic                    m_out_of_range
);

    logic         en;
    ddo_pkg::dn_t dn;
    ddo_pkg::sp_t sp;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    ddo_dayno u_dayno (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_valid),
        .day_in     (s_day_in),
        .month_in   (s_month_in),
        .year_in    (s_year_in),
        .day_offset (s_day_offset),
        .dn         (dn)
    );

    ddo_yoe u_yoe (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .dn      (dn),
        .sp      (sp)
    );

    ddo_civil u_civil (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .sp           (sp),
        .out_valid    (m_valid),
        .day_out      (m_day_out),
        .month_out    (m_month_out),
        .year_out     (m_year_out),
        .out_of_range (m_out_of_range)
    );

    // A result always names a real month and a day within it.
    a_date_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_day_out != 5'd0) && (m_month_out != 4'd0)
                    && (m_month_out <= 4'd12))
        else $error("result date fields out of calendar range");

    a_feb_days: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_month_out == 4'd2)) |-> (m_day_out <= 5'd29))
        else $error("February result past day 29");

    a_short_months: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && ((m_month_out == 4'd4) || (m_month_out == 4'd6)
                     || (m_month_out == 4'd9) || (m_month_out == 4'd11)))
        |-> (m_day_out <= 5'd30))
        else $error("30-day month result past day 30");

    a_flag_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_out_of_range)
        |-> (m_year_out >= 12'd1903) && (m_year_out <= 12'd2037))
        else $error("in-range flag with a year outside the window");

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam int REQUEST_COUNT = 1900;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 20;

    // Day number of 0000-03-01 counted back from 1970-01-01.
    localparam longint EPOCH_SHIFT = 719468;
    localparam longint DAYS_PER_ERA = 146097;
    localparam longint FIRST_YEAR = 1903;
    localparam longint LAST_YEAR  = 2037;

    typedef struct {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic        out_of_range;
    } date_result_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [4:0]          s_day_in;
    logic [3:0]          s_month_in;
    logic [10:0]         s_year_in;
    logic signed [16:0]  s_day_offset;
    logic                m_valid;
    logic                m_ready;
    logic [4:0]          m_day_out;
    logic [3:0]          m_month_out;
    logic [11:0]         m_year_out;
    logic                m_out_of_range;
    int                  cycle_count;

    function automatic longint floor_quot(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    // Days from 1970-01-01 to a proleptic Gregorian date, month 1..12.
    // The year is counted from March so that the leap day falls at the end.
    function automatic longint days_from_date(input longint y, input longint m,
                                              input longint d);
        longint era;
        longint yr_of_era;
        longint day_of_yr;
        longint day_of_era;
        if (m <= 2) begin
            y = y - 1;
        end
        era        = floor_quot(y, 400);
        yr_of_era  = y - era * 400;
        day_of_yr  = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
        day_of_era = yr_of_era * 365 + yr_of_era / 4 - yr_of_era / 100 + day_of_yr;
        return era * DAYS_PER_ERA + day_of_era - EPOCH_SHIFT;
    endfunction

    function automatic void date_from_days(input longint z, output longint y,
                                           output longint m, output longint d);
        longint era;
        longint day_of_era;
        longint yr_of_era;
        longint day_of_yr;
        longint mp;
        z          = z + EPOCH_SHIFT;
        era        = floor_quot(z, DAYS_PER_ERA);
        day_of_era = z - era * DAYS_PER_ERA;
        yr_of_era  = (day_of_era - day_of_era / 1460 + day_of_era / 36524
                      - day_of_era / 146096) / 365;
        day_of_yr  = day_of_era - (365 * yr_of_era + yr_of_era / 4 - yr_of_era / 100);
        mp         = (5 * day_of_yr + 2) / 153;
        d          = day_of_yr - (153 * mp + 2) / 5 + 1;
        m          = (mp < 10) ? mp + 3 : mp - 9;
        y          = yr_of_era + era * 400 + ((m <= 2) ? 1 : 0);
    endfunction

    class date_scoreboard;
        date_result_t expected_q[$];
        int           errors;

        function new();
            errors = 0;
        endfunction

        task report(input string what);
            $display("ERROR at %0t: %s", $realtime, what);
            errors++;
        endtask

        // Out-of-range day and month fields simply roll over, so the start is
        // the first of the normalized month plus (day - 1) days.
        function void note_request(input logic [4:0] day, input logic [3:0] month,
                                   input logic [10:0] year,
                                   input logic signed [16:0] offset);
            longint       mon0;
            longint       carry;
            longint       z;
            longint       ry;
            longint       rm;
            longint       rd;
            date_result_t res;
            mon0  = longint'(month) - 1;
            carry = floor_quot(mon0, 12);
            mon0  = mon0 - carry * 12;
            z = days_from_date(longint'(year) + carry, mon0 + 1, 1)
                + longint'(day) - 1 + longint'(offset);
            date_from_days(z, ry, rm, rd);
            res.day          = rd[4:0];
            res.month        = rm[3:0];
            res.year         = ry[11:0];
            res.out_of_range = (ry < FIRST_YEAR || ry > LAST_YEAR);
            expected_q.push_back(res);
        endfunction

        task check_result(input logic [4:0] day, input logic [3:0] month,
                          input logic [11:0] year, input logic out_of_range);
            date_result_t exp_res;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result %0d-%0d-%0d", year, month, day));
            end else begin
                exp_res = expected_q.pop_front();
                if (day !== exp_res.day) begin
                    report($sformatf("day_out %0d, want %0d", day, exp_res.day));
                end
                if (month !== exp_res.month) begin
                    report($sformatf("month_out %0d, want %0d", month, exp_res.month));
                end
                if (year !== exp_res.year) begin
                    report($sformatf("year_out %0d, want %0d", year, exp_res.year));
                end
                if (out_of_range !== exp_res.out_of_range) begin
                    report($sformatf("out_of_range %0b, want %0b", out_of_range,
                                     exp_res.out_of_range));
                end
            end
        endtask
    endclass

    date_scoreboard sb = new();

    date_day_offset dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_day_in       (s_day_in),
        .s_month_in     (s_month_in),
        .s_year_in      (s_year_in),
        .s_day_offset   (s_day_offset),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_day_out      (m_day_out),
        .m_month_out    (m_month_out),
        .m_year_out     (m_year_out),
        .m_out_of_range (m_out_of_range)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("date_day_offset: mismatch");
            $finish;
        end
    end

    // The receiver cycles through always-ready, coin-flip, periodic and
    // mostly-stalled windows of equal length.
    always @(negedge aclk) begin
        case ((cycle_count / 300) % 4)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 1) == 1);
            2:       m_ready <= ((cycle_count % 11) < 7);
            default: m_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_day_out, m_month_out, m_year_out, m_out_of_range);
        end
    end

    task automatic send_request(input logic [4:0] day, input logic [3:0] month,
                                input logic [10:0] year,
                                input logic signed [16:0] offset);
        @(negedge aclk);
        s_valid      = 1'b1;
        s_day_in     = day;
        s_month_in   = month;
        s_year_in    = year;
        s_day_offset = offset;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sb.note_request(day, month, year, offset);
    endtask

    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.expected_q.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Mostly calendar-valid starting dates with offsets that are small, full
    // range, or aimed at the edges of the flagged year window; the rest are
    // raw field values.
    task automatic send_random_request();
        longint             z;
        longint             y;
        longint             m;
        longint             d;
        longint             target;
        logic signed [16:0] offset;
        if ($urandom_range(0, 6) == 0) begin
            offset = 17'($urandom);
            send_request(5'($urandom), 4'($urandom), 11'($urandom), offset);
        end else begin
            z = days_from_date(FIRST_YEAR, 1, 1)
                + longint'($urandom_range(0, 49309));
            date_from_days(z, y, m, d);
            case ($urandom_range(0, 3))
                0: offset = 17'(longint'($urandom_range(0, 800)) - 400);
                1: offset = 17'($urandom);
                2: begin
                    target = days_from_date(FIRST_YEAR, 1, 1)
                             + longint'($urandom_range(0, 5)) - 3;
                    offset = 17'(target - z);
                end
                default: begin
                    target = days_from_date(LAST_YEAR + 1, 1, 1)
                             + longint'($urandom_range(0, 5)) - 3;
                    offset = 17'(target - z);
                end
            endcase
            send_request(d[4:0], m[3:0], y[10:0], offset);
        end
    endtask

    initial begin
        int sent;
        int burst;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_day_in     = '0;
        s_month_in   = '0;
        s_year_in    = '0;
        s_day_offset = '0;
        m_ready      = 1'b0;
        cycle_count  = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_request(5'd1,  4'd1,  11'd1903, 17'sd0);
        send_request(5'd31, 4'd12, 11'd2037, 17'sd0);
        send_request(5'd1,  4'd1,  11'd1903, -17'sd1);
        send_request(5'd31, 4'd12, 11'd2037, 17'sd1);
        send_request(5'd28, 4'd2,  11'd2000, 17'sd1);
        send_request(5'd28, 4'd2,  11'd1900, 17'sd1);
        send_request(5'd1,  4'd3,  11'd2100, -17'sd1);
        send_request(5'd29, 4'd2,  11'd2024, 17'sd365);
        // Day past the end of a 30-day month and day zero both roll over.
        send_request(5'd31, 4'd4,  11'd2021, 17'sd0);
        send_request(5'd0,  4'd3,  11'd2023, 17'sd0);
        send_request(5'd0,  4'd1,  11'd1903, 17'sd0);
        // Month zero and months past December carry into the year.
        send_request(5'd15, 4'd0,  11'd2020, 17'sd0);
        send_request(5'd15, 4'd15, 11'd2020, 17'sd0);
        send_request(5'd0,  4'd0,  11'd0,    17'sd0);
        // A computed year below zero wraps in the year field.
        send_request(5'd0,  4'd0,  11'd0,    -17'sd65536);
        send_request(5'd31, 4'd15, 11'd2047, 17'sd65535);
        send_request(5'd31, 4'd15, 11'd2047, -17'sd65536);
        send_request(5'd1,  4'd1,  11'd1903, 17'sd65535);
        send_request(5'd31, 4'd12, 11'd2037, -17'sd65536);
        send_request(5'd30, 4'd1,  11'd1970, -17'sd10000);
        send_request(5'd10, 4'd8,  11'd1999, 17'sd3);
        wait_drained();

        sent = 0;
        while (sent < REQUEST_COUNT) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && sent < REQUEST_COUNT) begin
                send_random_request();
                sent++;
                burst--;
                if (sent == REQUEST_COUNT / 2) begin
                    wait_drained();
                end
            end
            if ($urandom_range(0, 3) != 0) begin
                idle_sender($urandom_range(1, 6));
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("date_day_offset: match");
        end else begin
            $display("date_day_offset: mismatch");
        end
        $finish;
    end

endmodule
